// File: rtl/tcrp_pkg.sv
// Shared types and constants of the timecode range parser.
package tcrp_pkg;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BADNUM  = 3'd1;
    localparam logic [2:0] ST_RANGE   = 3'd2;
    localparam logic [2:0] ST_HYPHEN  = 3'd3;
    localparam logic [2:0] ST_GARBAGE = 3'd4;
    localparam logic [2:0] ST_NORANGE = 3'd5;

    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [1:0] REG_SEPARATOR = 2'd0;
    localparam logic [1:0] REG_FPS       = 2'd1;

    // Result of parsing one character.
    typedef struct packed {
        logic       emit;
        logic       good;
        logic [2:0] status;
        logic [15:0] offset;
        logic       last;
    } tcrp_status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic parse;
        logic conv_start;
    } tcrp_cmd_t;

endpackage

// File: rtl/tcrp_parser.sv
// Character parser datapath: number accumulation, field storage and error tracking.
module tcrp_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tcrp_pkg::tcrp_cmd_t   cmd,
    input  logic [7:0]            ch,
    input  logic                  last,
    input  logic [7:0]            separator,
    output tcrp_pkg::tcrp_status_t stat,
    output logic [31:0]           time_h [2],
    output logic [31:0]           time_m [2],
    output logic [31:0]           time_s [2],
    output logic [31:0]           time_f [2],
    output logic [31:0]           step_out
);
    import tcrp_pkg::*;

    localparam logic [1:0] PH_SKIP     = 2'd0;
    localparam logic [1:0] PH_NUMSTART = 2'd1;
    localparam logic [1:0] PH_INNUM    = 2'd2;
    localparam logic [32:0] CLAMP = 33'h1_0000_0000;

    logic [1:0]  phase_reg, phase_next;
    logic [32:0] acc_reg, acc_next;
    logic [31:0] tf_reg [8];
    logic [31:0] tf_next [8];
    logic [1:0]  cnt_reg, cnt_next;
    logic        dot_reg, dot_next;
    logic [1:0]  part_reg, part_next;
    logic [31:0] step_reg, step_next;
    logic [15:0] off_reg, off_next;
    logic [15:0] nstart_reg, nstart_next;
    logic [18:0] perr_reg, perr_next;
    logic        disc_reg, disc_next;
    tcrp_status_t stat_next;

    logic        is_sep, is_digit;
    logic [3:0]  dval;
    logic [36:0] mul10;
    logic [1:0]  r;
    logic [2:0]  fst;
    logic [15:0] foff;
    logic [2:0]  b;
    logic        term;

    assign is_sep   = (ch == separator);
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign dval     = 4'(ch - CH_ZERO);
    assign mul10    = {acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {33'd0, dval};

    always_comb begin
        logic [31:0] v;
        logic [31:0] r0, r1, r2, fr;
        logic        cont;
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        tf_next     = tf_reg;
        cnt_next    = cnt_reg;
        dot_next    = dot_reg;
        part_next   = part_reg;
        step_next   = step_reg;
        off_next    = off_reg;
        nstart_next = nstart_reg;
        perr_next   = perr_reg;
        disc_next   = disc_reg;
        stat_next   = '0;
        r           = 2'd0;
        fst         = ST_OK;
        foff        = '0;
        b           = 3'd0;
        term        = 1'b0;
        v           = '0;
        r0 = '0; r1 = '0; r2 = '0; fr = '0;
        cont        = 1'b1;
        if (cmd.parse) begin
            if (disc_reg) begin
                cont = 1'b0;
                if (last) begin
                    stat_next.emit   = 1'b1;
                    stat_next.status = perr_reg[18:16];
                    stat_next.offset = perr_reg[15:0];
                    stat_next.last   = 1'b1;
                    perr_next = '0;
                    disc_next = 1'b0;
                    phase_next = PH_SKIP;
                end
            end else if (phase_reg == PH_SKIP && is_sep) begin
                cont = 1'b0;
                if (last) begin
                    stat_next.emit   = 1'b1;
                    stat_next.status = ST_NORANGE;
                    stat_next.last   = 1'b1;
                end
            end else if (phase_reg == PH_SKIP) begin
                for (int i = 0; i < 8; i++) tf_next[i] = '0;
                cnt_next = '0; dot_next = 1'b0; part_next = '0;
                step_next = 32'd1; off_next = '0; acc_next = '0;
                nstart_next = '0; phase_next = PH_NUMSTART;
            end
            // Up to two passes: the character itself, then the end mark on last.
            for (int pass = 0; pass < 2; pass++) begin
                if (cont) begin
                    term = (pass == 1) || is_sep;
                    r = 2'd0;
                    if (phase_next == PH_NUMSTART) begin
                        if (term || !is_digit) begin
                            r = 2'd2; fst = ST_BADNUM; foff = off_next;
                        end else begin
                            acc_next = {29'd0, dval};
                            nstart_next = off_next;
                            phase_next = PH_INNUM;
                        end
                    end else if (!term && is_digit) begin
                        acc_next = (mul10 > {4'd0, CLAMP}) ? CLAMP : mul10[32:0];
                    end else if (acc_next[32]) begin
                        r = 2'd2; fst = ST_RANGE; foff = nstart_next;
                    end else begin
                        v = acc_next[31:0];
                        if (part_next[1]) begin
                            step_next = v;
                        end else if (dot_next) begin
                            tf_next[{part_next[0], 2'd3}] = v;
                        end else begin
                            tf_next[{part_next[0], cnt_next}] = v;
                            cnt_next = cnt_next + 2'd1;
                        end
                        if (part_next[1]) begin
                            if (term) r = 2'd1;
                            else begin r = 2'd2; fst = ST_GARBAGE; foff = off_next; end
                        end else if (!dot_next && !term && ch == CH_COLON
                                     && cnt_next != 2'd3) begin
                            phase_next = PH_NUMSTART;
                        end else if (!dot_next && !term && ch == CH_DOT) begin
                            dot_next = 1'b1;
                            phase_next = PH_NUMSTART;
                        end else begin
                            b  = {part_next[0], 2'd0};
                            r0 = tf_next[b]; r1 = tf_next[b + 3'd1];
                            r2 = tf_next[b + 3'd2];
                            fr = dot_next ? tf_next[b + 3'd3] : 32'd0;
                            if (cnt_next <= 2'd1) begin
                                tf_next[b] = '0; tf_next[b + 3'd1] = '0;
                                tf_next[b + 3'd2] = dot_next ? r0 : 32'd0;
                                tf_next[b + 3'd3] = dot_next ? fr : r0;
                            end else if (cnt_next == 2'd2) begin
                                tf_next[b] = '0; tf_next[b + 3'd1] = r0;
                                tf_next[b + 3'd2] = r1; tf_next[b + 3'd3] = fr;
                            end else begin
                                tf_next[b + 3'd3] = fr;
                            end
                            if (!part_next[0]) begin
                                if (!term && ch == CH_HYPHEN) begin
                                    cnt_next = '0; dot_next = 1'b0; part_next = 2'd1;
                                    phase_next = PH_NUMSTART;
                                end else begin
                                    r = 2'd2; fst = ST_HYPHEN; foff = off_next;
                                end
                            end else if (!term && ch == CH_SLASH) begin
                                cnt_next = '0; dot_next = 1'b0; part_next = 2'd2;
                                phase_next = PH_NUMSTART;
                            end else if (term) begin
                                r = 2'd1;
                            end else begin
                                r = 2'd2; fst = ST_GARBAGE; foff = off_next;
                            end
                        end
                    end
                    if (r == 2'd0 && pass == 0 && !is_sep) begin
                        if (off_next != 16'hFFFF) off_next = off_next + 16'd1;
                        cont = last;
                    end else begin
                        cont = 1'b0;
                    end
                    if (r == 2'd1) begin
                        stat_next.emit = 1'b1;
                        stat_next.good = 1'b1;
                        stat_next.last = last;
                        phase_next = PH_SKIP;
                    end else if (r == 2'd2) begin
                        if (last) begin
                            stat_next.emit   = 1'b1;
                            stat_next.status = fst;
                            stat_next.offset = foff;
                            stat_next.last   = 1'b1;
                            perr_next = '0;
                            disc_next = 1'b0;
                            phase_next = PH_SKIP;
                        end else begin
                            perr_next = {fst, foff};
                            disc_next = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SKIP;
            cnt_reg   <= '0;
            dot_reg   <= 1'b0;
            part_reg  <= '0;
            perr_reg  <= '0;
            disc_reg  <= 1'b0;
            stat      <= '0;
            step_reg  <= 32'd1;
            off_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            dot_reg   <= dot_next;
            part_reg  <= part_next;
            perr_reg  <= perr_next;
            disc_reg  <= disc_next;
            stat      <= stat_next;
            step_reg  <= step_next;
            off_reg   <= off_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        tf_reg     <= tf_next;
        nstart_reg <= nstart_next;
    end

    assign step_out = step_reg;
    always_comb begin
        for (int p = 0; p < 2; p++) begin
            time_h[p] = tf_reg[{p[0], 2'd0}];
            time_m[p] = tf_reg[{p[0], 2'd1}];
            time_s[p] = tf_reg[{p[0], 2'd2}];
            time_f[p] = tf_reg[{p[0], 2'd3}];
        end
    end

endmodule

// File: rtl/tcrp_frame_conv.sv
// Multicycle time to frame converter: seconds times fps plus frames, saturated.
module tcrp_frame_conv #(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] hours,
    input  logic [31:0] minutes,
    input  logic [31:0] seconds,
    input  logic [31:0] frames,
    input  logic [31:0] fps,
    output logic        done,
    output logic [31:0] frame
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HM   = 3'd1;
    localparam logic [2:0] S_SEC  = 3'd2;
    localparam logic [2:0] S_LO   = 3'd3;
    localparam logic [2:0] S_HI   = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;

    logic [2:0]  st_reg, st_next;
    logic [43:0] secs_reg, secs_next;
    logic [63:0] lo_reg, lo_next;
    logic [43:0] hi_reg, hi_next;
    logic [31:0] frame_reg, frame_next;
    logic        done_reg, done_next;
    logic [65:0] total;

    assign total = {2'd0, hi_reg[31:0], 32'd0} >> FRAC_BITS;

    always_comb begin
        logic [65:0] sum;
        st_next    = st_reg;
        secs_next  = secs_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        frame_next = frame_reg;
        done_next  = 1'b0;
        sum        = '0;
        case (st_reg)
            S_IDLE: if (start) begin
                secs_next = {12'd0, hours} * 44'd60 + {12'd0, minutes};
                st_next = S_HM;
            end
            S_HM: begin
                secs_next = secs_reg * 44'd60 + {12'd0, seconds};
                st_next = S_SEC;
            end
            S_SEC: begin
                lo_next = {32'd0, secs_reg[31:0]} * {32'd0, fps};
                st_next = S_LO;
            end
            S_LO: begin
                hi_next = {32'd0, secs_reg[43:32]} * {12'd0, fps};
                st_next = S_HI;
            end
            S_HI: st_next = S_SUM;
            S_SUM: begin
                sum = total + {2'd0, lo_reg >> FRAC_BITS} + {34'd0, frames};
                if ((hi_reg >> FRAC_BITS) != 44'd0 || sum[65:32] != 34'd0)
                    frame_next = 32'hFFFF_FFFF;
                else
                    frame_next = sum[31:0];
                done_next = 1'b1;
                st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= S_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        secs_reg  <= secs_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        frame_reg <= frame_next;
    end

    assign done  = done_reg;
    assign frame = frame_reg;

endmodule

// File: rtl/tcrp_ctrl.sv
// Control state machine: handshakes, parse strobe, conversions and result holding.
module tcrp_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    output tcrp_pkg::tcrp_cmd_t    cmd,
    input  tcrp_pkg::tcrp_status_t stat,
    output logic                   sel_end,
    input  logic                   conv_done,
    output logic                   cap_start,
    output logic                   cap_end,
    output logic                   cap_err
);
    import tcrp_pkg::*;

    localparam logic [2:0] C_IDLE  = 3'd0;
    localparam logic [2:0] C_CHECK = 3'd1;
    localparam logic [2:0] C_CONV0 = 3'd2;
    localparam logic [2:0] C_CONV1 = 3'd3;
    localparam logic [2:0] C_OUT   = 3'd4;
    localparam logic [2:0] C_KICK1 = 3'd5;

    logic [2:0] st_reg, st_next;

    assign s_ready = (st_reg == C_IDLE);
    assign m_valid = (st_reg == C_OUT);
    assign cmd.parse = s_valid && s_ready;
    assign cmd.conv_start = (st_reg == C_CHECK && stat.emit && stat.good)
                            || st_reg == C_KICK1;
    assign sel_end   = (st_reg == C_CONV1) || (st_reg == C_KICK1);
    assign cap_start = (st_reg == C_CONV0) && conv_done;
    assign cap_end   = (st_reg == C_CONV1) && conv_done;
    assign cap_err   = (st_reg == C_CHECK);

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            C_IDLE:  if (s_valid) st_next = C_CHECK;
            C_CHECK: begin
                if (!stat.emit) st_next = C_IDLE;
                else if (stat.good) st_next = C_CONV0;
                else st_next = C_OUT;
            end
            C_CONV0: if (conv_done) st_next = C_KICK1;
            C_KICK1: st_next = C_CONV1;
            C_CONV1: if (conv_done) st_next = C_OUT;
            C_OUT:   if (m_ready) st_next = C_IDLE;
            default: st_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) st_reg <= C_IDLE;
        else st_reg <= st_next;
    end

endmodule

// File: rtl/timecode_range_parser_core.sv
// Top level of the timecode range parser.
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    s_char_code, s_last_char
//   m_       out        m_valid/m_ready    m_start_frame .. m_stream_end
//   cfg      in         cfg_we             cfg_index, cfg_data
// A character that yields no result returns from the check state to idle; a good
// range result makes two passes through the shared multicycle converter; error and
// no-range results go from check to output. Reset is synchronous, active low.
// The result is held in the output register until m_ready; input waits meanwhile.
module timecode_range_parser_core #(
    parameter int FPS_FRACTION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_last_char,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_start_frame,
    output logic [31:0] m_end_frame,
    output logic [31:0] m_step_frames,
    output logic [2:0]  m_status,
    output logic [15:0] m_error_offset,
    output logic        m_stream_end,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import tcrp_pkg::*;

    logic [7:0]   sep_reg;
    logic [31:0]  fps_reg;
    tcrp_cmd_t    cmd;
    tcrp_status_t stat;
    logic [31:0]  th [2];
    logic [31:0]  tm [2];
    logic [31:0]  ts [2];
    logic [31:0]  tf [2];
    logic [31:0]  step;
    logic         sel_end, conv_done, cap_start, cap_end, cap_err;
    logic [31:0]  frame;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sep_reg <= 8'd44;
            fps_reg <= 32'd25 << FPS_FRACTION_BITS;
        end else if (cfg_we) begin
            if (cfg_index == REG_SEPARATOR) sep_reg <= cfg_data[7:0];
            else if (cfg_index == REG_FPS) fps_reg <= cfg_data;
        end
    end

    tcrp_parser u_parser (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .ch(s_char_code),
        .last(s_last_char), .separator(sep_reg), .stat(stat),
        .time_h(th), .time_m(tm), .time_s(ts), .time_f(tf), .step_out(step)
    );

    tcrp_frame_conv #(.FRAC_BITS(FPS_FRACTION_BITS)) u_conv (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.conv_start),
        .hours(th[sel_end]), .minutes(tm[sel_end]), .seconds(ts[sel_end]),
        .frames(tf[sel_end]), .fps(fps_reg), .done(conv_done), .frame(frame)
    );

    tcrp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd), .stat(stat),
        .sel_end(sel_end), .conv_done(conv_done), .cap_start(cap_start),
        .cap_end(cap_end), .cap_err(cap_err)
    );

    always_ff @(posedge aclk) begin
        if (cap_err) begin
            m_start_frame  <= '0;
            m_end_frame    <= '0;
            m_step_frames  <= stat.good ? step : 32'd0;
            m_status       <= stat.status;
            m_error_offset <= stat.offset;
            m_stream_end   <= stat.last;
        end
        if (cap_start) m_start_frame <= frame;
        if (cap_end) m_end_frame <= frame;
    end

`ifndef SYNTH
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result changed while stalled");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while a result waits");
    a_ok_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_OK || m_status == ST_NORANGE) |-> m_error_offset == 16'd0)
        else $error("offset set on a result without error");
`endif

endmodule
